// File: sv/ihex_pkg.sv
// Shared types, codes and helpers for the hex record parser.
// No dependencies; imported by the parser top level.
package ihex_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [9:0] DIGIT_MAX    = 10'd1023;
   localparam logic [9:0] DIGIT_MIN    = 10'd10;
   localparam logic [23:0] REPORT_MAX  = 24'hffffff;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_COLON = 3'd1;
   localparam logic [2:0] ST_BAD_LEN  = 3'd2;
   localparam logic [2:0] ST_BAD_HEX  = 3'd3;
   localparam logic [2:0] ST_BAD_CNT  = 3'd4;
   localparam logic [2:0] ST_CHECKSUM = 3'd5;

   localparam logic [7:0] RTYPE_DATA = 8'd0;
   localparam logic [7:0] RTYPE_EOF  = 8'd1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [2:0]  status;
      logic [7:0]  record_type;
      logic [23:0] total_bytes;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: sv/intel_hex_record_parser.sv
// Streaming hex record parser: one character per request, results through a small queue.
// Depends on ihex_pkg.
// A result is written into the queue when its request is accepted and offered on rsp in turn.
// Throughput: one character per cycle while req_tready is high; end of stream with an open
// line gives two results, written together. req_tready is low while fewer than two queue
// entries are free. Reset (synchronous) clears parser state, byte count and queue.
module intel_hex_record_parser #(
   parameter int COUNT_BITS = ihex_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // char_code
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // data_byte, status, record_type, total_bytes, zero pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);
   import ihex_pkg::*;

   localparam logic [2:0] PH_COLON   = 3'd0;
   localparam logic [2:0] PH_REC     = 3'd1;
   localparam logic [2:0] PH_BADHEX  = 3'd2;
   localparam logic [2:0] PH_NOCOLON = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   logic [2:0]            phase_ff, phase_in;
   logic [9:0]            digit_ff, digit_in;
   logic [3:0]            nibble_ff, nibble_in;
   logic [7:0]            length_ff, length_in;
   logic [7:0]            rkind_ff, rkind_in;
   logic [7:0]            cksum_ff, cksum_in;
   logic                  eof_ff, eof_in;
   logic [2:0]            sticky_ff, sticky_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [7:0]            pending_ff, pending_in;

   rsp_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   logic                  req_fire, rsp_fire;
   logic [2:0]            le_status;
   logic [COUNT_BITS:0]   le_sum;
   logic [COUNT_BITS-1:0] le_total;
   logic [COUNT_BITS-1:0] total_eff;
   logic [2:0]            sticky_eff;
   logic [31:0]           total_wide;
   logic [23:0]           report_total;
   hex_type               hex;
   logic [9:0]            digit_next;
   logic [7:0]            byte_val;
   logic [8:0]            pair;
   logic [1:0]            n_res;
   rsp_type               res0, res1;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
   assign rsp_tvalid = count_ff != '0;

   assign rsp_tdata = {5'd0, queue_ff[rd_ptr_ff].total_bytes, queue_ff[rd_ptr_ff].record_type,
                       queue_ff[rd_ptr_ff].status, queue_ff[rd_ptr_ff].data_byte};
   assign rsp_tuser = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

   always_comb begin
      if (phase_ff == PH_COLON || phase_ff == PH_NOCOLON) begin
         le_status = ST_NO_COLON;
      end else if (digit_ff[0] || digit_ff < DIGIT_MIN) begin
         le_status = ST_BAD_LEN;
      end else if (phase_ff == PH_BADHEX) begin
         le_status = ST_BAD_HEX;
      end else if (digit_ff != 10'({length_ff, 1'b0}) + DIGIT_MIN) begin
         le_status = ST_BAD_CNT;
      end else if (cksum_ff != 8'd0) begin
         le_status = ST_CHECKSUM;
      end else begin
         le_status = ST_OK;
      end
   end

   assign le_sum   = {1'b0, total_ff} + (COUNT_BITS+1)'(pending_ff);
   assign le_total = le_sum[COUNT_BITS] ? '1 : le_sum[COUNT_BITS-1:0];

   assign hex        = hex_decode(req_tdata);
   assign digit_next = digit_ff + 10'd1;
   assign byte_val   = {nibble_ff, hex.value};
   assign pair       = digit_next[9:1] - 9'd1;

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      nibble_in  = nibble_ff;
      length_in  = length_ff;
      rkind_in   = rkind_ff;
      cksum_in   = cksum_ff;
      eof_in     = eof_ff;
      sticky_in  = sticky_ff;
      total_in   = total_ff;
      pending_in = pending_ff;
      n_res      = 2'd0;
      res0       = '0;
      res1       = '0;
      total_eff  = total_ff;
      sticky_eff = sticky_ff;
      total_wide = 32'(total_ff);
      report_total = 24'd0;
      if (req_tlast) begin
         if (phase_ff == PH_REC || phase_ff == PH_BADHEX || phase_ff == PH_NOCOLON) begin
            res0.kind        = KIND_STATUS;
            res0.status      = le_status;
            res0.record_type = rkind_ff;
            n_res            = 2'd1;
            if (le_status != ST_OK) begin
               sticky_eff = le_status;
            end else if (rkind_ff == RTYPE_DATA) begin
               total_eff = le_total;
            end
         end
         total_wide   = 32'(total_eff);
         report_total = (total_wide > 32'(REPORT_MAX)) ? REPORT_MAX : total_wide[23:0];
         if (n_res == 2'd1) begin
            res1.kind        = KIND_REPORT;
            res1.status      = sticky_eff;
            res1.total_bytes = report_total;
            res1.last        = 1'b1;
            n_res            = 2'd2;
         end else begin
            res0.kind        = KIND_REPORT;
            res0.status      = sticky_eff;
            res0.total_bytes = report_total;
            res0.last        = 1'b1;
            n_res            = 2'd1;
         end
         phase_in   = PH_COLON;
         digit_in   = '0;
         nibble_in  = '0;
         length_in  = '0;
         rkind_in   = '0;
         cksum_in   = '0;
         eof_in     = 1'b0;
         sticky_in  = ST_OK;
         total_in   = '0;
         pending_in = '0;
      end else if (phase_ff == PH_DONE) begin
         n_res = 2'd0;
      end else if (req_tdata == CHAR_NEWLINE) begin
         res0.kind        = KIND_STATUS;
         res0.status      = le_status;
         res0.record_type = rkind_ff;
         res0.last        = 1'b1;
         n_res            = 2'd1;
         if (le_status != ST_OK) begin
            sticky_in = le_status;
            phase_in  = PH_DONE;
         end else if (rkind_ff == RTYPE_DATA) begin
            total_in = le_total;
            phase_in = PH_COLON;
         end else if (rkind_ff == RTYPE_EOF) begin
            eof_in   = 1'b1;
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_COLON;
         end
         digit_in   = '0;
         nibble_in  = '0;
         length_in  = '0;
         rkind_in   = '0;
         cksum_in   = '0;
         pending_in = '0;
      end else if (phase_ff == PH_COLON) begin
         digit_in   = '0;
         nibble_in  = '0;
         length_in  = '0;
         rkind_in   = '0;
         cksum_in   = '0;
         pending_in = '0;
         phase_in   = (req_tdata == CHAR_COLON) ? PH_REC : PH_NOCOLON;
      end else if (phase_ff == PH_NOCOLON) begin
         n_res = 2'd0;
      end else begin
         if (!hex.ok) begin
            phase_in = PH_BADHEX;
         end
         if (digit_ff < DIGIT_MAX) begin
            digit_in = digit_next;
            if (digit_next[0]) begin
               nibble_in = hex.value;
            end else begin
               cksum_in = cksum_ff + byte_val;
               if (pair == 9'd0) begin
                  length_in = byte_val;
               end else if (pair == 9'd3) begin
                  rkind_in = byte_val;
               end else if (pair >= 9'd4 && 10'(pair) < 10'd4 + 10'(length_ff) &&
                            rkind_ff == RTYPE_DATA && phase_ff == PH_REC && hex.ok) begin
                  res0.kind      = KIND_DATA;
                  res0.data_byte = byte_val;
                  res0.last      = 1'b1;
                  n_res          = 2'd1;
                  pending_in     = pending_ff + 8'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COLON;
         digit_ff   <= '0;
         nibble_ff  <= '0;
         length_ff  <= '0;
         rkind_ff   <= '0;
         cksum_ff   <= '0;
         eof_ff     <= 1'b0;
         sticky_ff  <= ST_OK;
         total_ff   <= '0;
         pending_ff <= '0;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         digit_ff   <= digit_in;
         nibble_ff  <= nibble_in;
         length_ff  <= length_in;
         rkind_ff   <= rkind_in;
         cksum_ff   <= cksum_in;
         eof_ff     <= eof_in;
         sticky_ff  <= sticky_in;
         total_ff   <= total_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (req_fire && n_res == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + (req_fire ? QUEUE_AW'(n_res) : QUEUE_AW'(0));
         rd_ptr_ff <= rd_ptr_ff + (rsp_fire ? QUEUE_AW'(1) : QUEUE_AW'(0));
         count_ff  <= count_ff + (req_fire ? (QUEUE_AW+1)'(n_res) : (QUEUE_AW+1)'(0))
                      - (rsp_fire ? (QUEUE_AW+1)'(1) : (QUEUE_AW+1)'(0));
      end
   end

   a_eof_done: assert property (@(posedge clock) disable iff (reset)
      eof_ff |-> phase_ff == PH_DONE)
      else $error("end-of-file flag set outside done phase");

   a_sticky_done: assert property (@(posedge clock) disable iff (reset)
      sticky_ff != ST_OK |-> phase_ff == PH_DONE)
      else $error("sticky error set while still parsing");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_eos_clear: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> phase_ff == PH_COLON && total_ff == '0 && sticky_ff == ST_OK)
      else $error("end of stream did not restart the parser");

endmodule
